// ===== hw/rtl/bmm_pkg.sv =====
// bmm_pkg: shared constants and types for the bipartite matching block
// no dependencies
`timescale 1ns / 1ps
package bmm_pkg;
  localparam int MaxLeft  = 64;
  localparam int MaxRight = 64;
  localparam int LW = $clog2(MaxLeft);
  localparam int RW = $clog2(MaxRight);
  localparam int CW = 7;

  // configuration register indexes
  localparam logic CfgLeft  = 1'b0;
  localparam logic CfgRight = 1'b1;

  typedef logic [LW-1:0] lidx_t;
  typedef logic [RW-1:0] ridx_t;
  typedef logic [MaxRight-1:0] row_t;

  // one search stack frame: left vertex and its right cursor
  typedef struct packed {
    lidx_t v;
    logic [RW:0] c;
  } frame_t;

  // status from the search engine to the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic [CW-1:0] count;
  } srch_stat_t;
endpackage

// ===== hw/rtl/bmm_search.sv =====
// bmm_search: kuhn augmenting-path sequencer with explicit stack and owner table
// depends on bmm_pkg
`timescale 1ns / 1ps
module bmm_search import bmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [CW-1:0] lc_in,
  input  logic [CW-1:0] rc_in,
  output lidx_t      row_addr,
  input  row_t       row_data,
  output srch_stat_t stat
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_AUG   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;

  logic [3:0] state_r;
  logic [CW-1:0] lc_r, rc_r;
  logic [LW:0] root_r;
  logic [LW:0] depth_r;
  logic [LW:0] k_r;
  logic [CW-1:0] total_r;
  row_t visited_r;
  logic [MaxRight-1:0] owned_r;
  lidx_t top_v_r;
  logic [RW:0] top_c_r;
  lidx_t owner_r [MaxRight];
  frame_t stk_r [MaxLeft];
  lidx_t owner_rd_r;
  frame_t stk_rd_r;

  ridx_t wi;
  lidx_t stk_raddr;

  // top frame lives in registers, the frames below it in stk_r
  assign wi = top_c_r[RW-1:0];
  assign row_addr = top_v_r;
  assign stk_raddr = (state_r == S_AUG) ? LW'(k_r - 2'd2) : LW'(depth_r - 2'd2);

  assign stat.busy  = (state_r != S_IDLE);
  assign stat.done  = (state_r == S_DONE);
  assign stat.count = total_r;

  always_ff @(posedge clk) begin
    owner_rd_r <= owner_r[wi];
    stk_rd_r <= stk_r[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      owned_r <= '0;
      total_r <= '0;
      depth_r <= '0;
      visited_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) begin
          lc_r <= (lc_in > CW'(MaxLeft)) ? CW'(MaxLeft) : lc_in;
          rc_r <= (rc_in > CW'(MaxRight)) ? CW'(MaxRight) : rc_in;
          owned_r <= '0;
          total_r <= '0;
          root_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if ({1'b0, root_r} >= (LW+2)'(lc_r)) state_r <= S_DONE;
          else begin
            visited_r <= '0;
            top_v_r <= LW'(root_r);
            top_c_r <= '0;
            depth_r <= (LW+1)'(1);
            state_r <= S_FETCH;
          end
        end
        // row of the new top vertex is read this cycle
        S_FETCH: state_r <= S_STEP;
        S_STEP: begin
          if ((CW+1)'(top_c_r) >= (CW+1)'(rc_r)) begin
            depth_r <= depth_r - 1'b1;
            if (depth_r == (LW+1)'(1)) begin
              root_r <= root_r + 1'b1;
              state_r <= S_ROOT;
            end else begin
              state_r <= S_POP;
            end
          end else if (!row_data[wi] || visited_r[wi]) begin
            top_c_r <= top_c_r + 1'b1;
          end else begin
            visited_r[wi] <= 1'b1;
            if (!owned_r[wi]) begin
              owner_r[wi] <= top_v_r;
              owned_r[wi] <= 1'b1;
              if (depth_r == (LW+1)'(1)) begin
                total_r <= total_r + 1'b1;
                depth_r <= '0;
                root_r <= root_r + 1'b1;
                state_r <= S_ROOT;
              end else begin
                k_r <= depth_r - 1'b1;
                state_r <= S_AUG;
              end
            end else if (depth_r < (LW+1)'(MaxLeft)) begin
              state_r <= S_PUSH;
            end else begin
              top_c_r <= top_c_r + 1'b1;
            end
          end
        end
        S_PUSH: begin
          if (CW'(owner_rd_r) < lc_r) begin
            stk_r[LW'(depth_r - 1'b1)] <= {top_v_r, top_c_r};
            top_v_r <= owner_rd_r;
            top_c_r <= '0;
            depth_r <= depth_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            top_c_r <= top_c_r + 1'b1;
            state_r <= S_STEP;
          end
        end
        S_POP: begin
          top_v_r <= stk_rd_r.v;
          top_c_r <= stk_rd_r.c + 1'b1;
          state_r <= S_FETCH;
        end
        S_AUG: begin
          // walk the saved frames writing new owners along the path
          owner_r[stk_rd_r.c[RW-1:0]] <= stk_rd_r.v;
          owned_r[stk_rd_r.c[RW-1:0]] <= 1'b1;
          k_r <= k_r - 1'b1;
          if (k_r == (LW+1)'(1)) begin
            total_r <= total_r + 1'b1;
            depth_r <= '0;
            root_r <= root_r + 1'b1;
            state_r <= S_ROOT;
          end
        end
        S_DONE: state_r <= S_CLR;
        S_CLR: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/bmm_adj.sv =====
// bmm_adj: adjacency bit matrix, row-set on load, cleared by a row sweep
// depends on bmm_pkg
`timescale 1ns / 1ps
module bmm_adj import bmm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  set_en,
  input  lidx_t set_row,
  input  ridx_t set_col,
  input  logic  clr_start,
  output logic  clr_busy,
  input  lidx_t rd_addr,
  output row_t  rd_data
);
  row_t rows_r [MaxLeft];
  logic clr_busy_r;
  lidx_t clr_idx_r;
  row_t rd_data_r;

  assign clr_busy = clr_busy_r;
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) rd_data_r <= rows_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_busy_r) begin
      rows_r[clr_idx_r] <= '0;
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LW'(MaxLeft - 1)) clr_busy_r <= 1'b0;
    end else if (clr_start) begin
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (set_en) begin
      rows_r[set_row][set_col] <= 1'b1;
    end
  end
endmodule

// ===== hw/rtl/bipartite_max_matching.sv =====
// bipartite_max_matching: top level, edge loading, search control, result register
// depends on bmm_pkg, bmm_adj, bmm_search
`timescale 1ns / 1ps
// Loads one edge transfer per cycle into a 64x64 adjacency matrix; edge transfers can
// follow back to back. The item with last_edge set (its edge loaded first) starts
// Kuhn's augmenting-path search in the next cycle; input is held off until the search,
// the matrix clear and the result transfer are all done. The search runs on one shared
// step unit: each left root is opened in the root and row-fetch states, each right is
// probed in the step state, a probe that pushes a frame and each pop back to a saved
// frame go through an owner or frame read, then the new row read, and the augment
// writes one new owner per saved frame on the path. When the search has passed the
// last root the result register loads, and the matrix is then cleared one row per
// cycle, as it also is once after reset.
module bipartite_max_matching import bmm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [5:0]    in_left_index,
  input  logic [5:0]    in_right_index,
  input  logic          in_edge_valid,
  input  logic          in_last_edge,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [6:0]    out_match_count,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data
);
  logic [CW-1:0] lc_r, rc_r;
  logic out_valid_r;
  logic [6:0] out_cnt_r;
  logic pend_r;
  logic clr_busy, start;
  lidx_t rd_addr;
  row_t rd_data;
  srch_stat_t stat;
  logic in_xfer;

  // accept edges only when search and clear are idle and no result waits
  assign in_ready = !pend_r && !stat.busy && !clr_busy && !out_valid_r;
  assign in_xfer = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_match_count = out_cnt_r;

  // search starts the cycle after the last item, once its edge is in the matrix
  assign start = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r <= 7'd64;
      rc_r <= 7'd64;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CfgLeft) lc_r <= cfg_data;
        else rc_r <= cfg_data;
      end
      if (in_xfer && in_last_edge) pend_r <= 1'b1;
      else if (pend_r) pend_r <= 1'b0;
      if (stat.done) begin
        out_valid_r <= 1'b1;
        out_cnt_r <= stat.count;
      end else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  bmm_adj u_adj (
    .clk, .rst_n,
    .set_en(in_xfer && in_edge_valid),
    .set_row(in_left_index), .set_col(in_right_index),
    .clr_start(stat.done), .clr_busy,
    .rd_addr, .rd_data
  );

  bmm_search u_srch (
    .clk, .rst_n, .start,
    .lc_in(lc_r), .rc_in(rc_r),
    .row_addr(rd_addr), .row_data(rd_data),
    .stat
  );
endmodule
